FILE: rtl/gtus_pkg.sv
package gtus_pkg;

  // stuffing characters
  localparam logic [7:0] CH_DLE = 8'd16;
  localparam logic [7:0] CH_ETX = 8'd3;
  localparam logic [7:0] CH_ACK = 8'd6;

  // register indexes on the APB port
  localparam logic [1:0] REG_EOI_ENABLE    = 2'd0;
  localparam logic [1:0] REG_BYTE_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_FIRST_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_TOTAL_TIMEOUT = 2'd3;

  // status codes
  localparam logic [2:0] ST_BUSY         = 3'd0;
  localparam logic [2:0] ST_DONE         = 3'd1;
  localparam logic [2:0] ST_NO_LISTENER  = 3'd2;
  localparam logic [2:0] ST_NOT_READY    = 3'd3;
  localparam logic [2:0] ST_NOT_ACCEPTED = 3'd4;
  localparam logic [2:0] ST_FORMAT       = 3'd5;
  localparam logic [2:0] ST_TIMEOUT      = 3'd6;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_HOST   = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_TICK   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LISTEN     = 3'd1,
    PH_HOST_FIRST = 3'd2,
    PH_HOST_NEXT  = 3'd3,
    PH_HS_NRFD    = 3'd4,
    PH_HS_NDAC    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    FO_DATA = 2'd0,
    FO_END  = 2'd1,
    FO_ACK  = 2'd2,
    FO_FMT  = 2'd3
  } follow_e;

  typedef struct packed {
    logic        eoi_enable;
    logic [7:0]  byte_timeout;
    logic [15:0] first_timeout;
    logic [15:0] total_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] host_byte;
    logic       nrfd_released;
    logic       ndac_released;
  } item_t;

  typedef struct packed {
    logic [7:0] data_lines;
    logic       dav_assert;
    logic       eoi_assert;
    logic       need_host_byte;
    logic       host_ack;
    logic [2:0] status;
  } result_t;

endpackage

FILE: rtl/gtus_ifs.sv
interface gtus_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] host_byte;
  logic       nrfd_released;
  logic       ndac_released;

  modport source (output valid, action, host_byte, nrfd_released, ndac_released,
                  input ready);
  modport sink (input valid, action, host_byte, nrfd_released, ndac_released,
                output ready);
endinterface

interface gtus_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_lines;
  logic       dav_assert;
  logic       eoi_assert;
  logic       need_host_byte;
  logic       host_ack;
  logic [2:0] status;

  modport source (output valid, data_lines, dav_assert, eoi_assert, need_host_byte,
                  host_ack, status, input ready);
  modport sink (input valid, data_lines, dav_assert, eoi_assert, need_host_byte,
                host_ack, status, output ready);
endinterface

FILE: rtl/gtus_cfg.sv
module gtus_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gtus_pkg::cfg_t     cfg_o
);

  gtus_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        gtus_pkg::REG_EOI_ENABLE:    cfg_d.eoi_enable    = pwdata[0];
        gtus_pkg::REG_BYTE_TIMEOUT:  cfg_d.byte_timeout  = pwdata[7:0];
        gtus_pkg::REG_FIRST_TIMEOUT: cfg_d.first_timeout = pwdata[15:0];
        gtus_pkg::REG_TOTAL_TIMEOUT: cfg_d.total_timeout = pwdata[15:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gtus_pkg::REG_EOI_ENABLE:    prdata = {31'd0, cfg_q.eoi_enable};
      gtus_pkg::REG_BYTE_TIMEOUT:  prdata = {24'd0, cfg_q.byte_timeout};
      gtus_pkg::REG_FIRST_TIMEOUT: prdata = {16'd0, cfg_q.first_timeout};
      gtus_pkg::REG_TOTAL_TIMEOUT: prdata = {16'd0, cfg_q.total_timeout};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eoi_enable    <= 1'b1;
      cfg_q.byte_timeout  <= 8'd30;
      cfg_q.first_timeout <= 16'd30;
      cfg_q.total_timeout <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/gtus_step.sv
module gtus_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gtus_pkg::cfg_t      cfg_i,
  input  logic                fire_i,
  input  gtus_pkg::item_t     item_i,
  output gtus_pkg::result_t   res_o
);

  gtus_pkg::phase_e  phase_q, phase_d;
  gtus_pkg::follow_e follow_q, follow_d;
  logic [7:0]        pending_q, pending_d;
  logic [7:0]        inc_q, inc_d;
  logic              esc_q, esc_d;
  logic              first_q, first_d;
  logic [15:0]       bticks_q, bticks_d;
  logic [15:0]       blk_q, blk_d;
  logic [2:0]        err_q, err_d;

  logic              ack;
  logic              fin;
  logic [2:0]        fin_code;
  logic [15:0]       bticks_inc;
  logic [15:0]       blk_inc;
  logic [15:0]       limit;
  logic              in_wait;
  logic              expired;
  logic [2:0]        wait_code;
  logic [7:0]        hb;

  assign hb         = item_i.host_byte;
  assign bticks_inc = (bticks_q != 16'hFFFF) ? bticks_q + 16'd1 : bticks_q;
  assign blk_inc    = (blk_q != 16'hFFFF) ? blk_q + 16'd1 : blk_q;
  assign limit      = first_q ? cfg_i.first_timeout : {8'd0, cfg_i.byte_timeout};
  assign in_wait    = (phase_q == gtus_pkg::PH_LISTEN) || (phase_q == gtus_pkg::PH_HS_NRFD) ||
                      (phase_q == gtus_pkg::PH_HS_NDAC);
  assign expired    = ((cfg_i.total_timeout != 16'd0) && (blk_inc >= cfg_i.total_timeout)) ||
                      (in_wait && (limit != 16'd0) && (bticks_inc >= limit));

  always_comb begin
    unique case (phase_q)
      gtus_pkg::PH_LISTEN:  wait_code = gtus_pkg::ST_NO_LISTENER;
      gtus_pkg::PH_HS_NRFD: wait_code = gtus_pkg::ST_NOT_READY;
      gtus_pkg::PH_HS_NDAC: wait_code = gtus_pkg::ST_NOT_ACCEPTED;
      default:              wait_code = gtus_pkg::ST_TIMEOUT;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    follow_d  = follow_q;
    pending_d = pending_q;
    inc_d     = inc_q;
    esc_d     = esc_q;
    first_d   = first_q;
    bticks_d  = bticks_q;
    blk_d     = blk_q;
    err_d     = err_q;
    ack       = 1'b0;
    fin       = 1'b0;
    fin_code  = gtus_pkg::ST_DONE;

    unique case (gtus_pkg::action_e'(item_i.action))
      gtus_pkg::ACT_START: begin
        phase_d   = gtus_pkg::PH_LISTEN;
        pending_d = 8'd0;
        esc_d     = 1'b0;
        first_d   = 1'b1;
        bticks_d  = 16'd0;
        blk_d     = 16'd0;
        err_d     = gtus_pkg::ST_BUSY;
        inc_d     = 8'd0;
        follow_d  = gtus_pkg::FO_DATA;
      end
      gtus_pkg::ACT_HOST: begin
        if (phase_q == gtus_pkg::PH_HOST_FIRST) begin
          if (!esc_q) begin
            if (hb == gtus_pkg::CH_DLE) begin
              esc_d = 1'b1;
            end else begin
              pending_d = hb;
              phase_d   = gtus_pkg::PH_HOST_NEXT;
            end
          end else begin
            esc_d = 1'b0;
            if (hb == gtus_pkg::CH_DLE) begin
              pending_d = gtus_pkg::CH_DLE;
              phase_d   = gtus_pkg::PH_HOST_NEXT;
            end else if (hb == gtus_pkg::CH_ETX) begin
              fin = 1'b1;
            end else if (hb == gtus_pkg::CH_ACK) begin
              ack = 1'b1;
            end else begin
              fin      = 1'b1;
              fin_code = gtus_pkg::ST_FORMAT;
            end
          end
        end else if (phase_q == gtus_pkg::PH_HOST_NEXT) begin
          if (!esc_q && hb == gtus_pkg::CH_DLE) begin
            esc_d = 1'b1;
          end else begin
            // a further word decides how the pending byte goes out
            esc_d    = 1'b0;
            bticks_d = 16'd0;
            phase_d  = gtus_pkg::PH_HS_NRFD;
            inc_d    = 8'd0;
            if (!esc_q) begin
              follow_d = gtus_pkg::FO_DATA;
              inc_d    = hb;
            end else if (hb == gtus_pkg::CH_DLE) begin
              follow_d = gtus_pkg::FO_DATA;
              inc_d    = gtus_pkg::CH_DLE;
            end else if (hb == gtus_pkg::CH_ETX) begin
              follow_d = gtus_pkg::FO_END;
            end else if (hb == gtus_pkg::CH_ACK) begin
              follow_d = gtus_pkg::FO_ACK;
            end else begin
              follow_d = gtus_pkg::FO_FMT;
            end
          end
        end
      end
      gtus_pkg::ACT_SAMPLE: begin
        if (phase_q == gtus_pkg::PH_LISTEN) begin
          if (!(item_i.nrfd_released && item_i.ndac_released)) begin
            phase_d  = gtus_pkg::PH_HOST_FIRST;
            bticks_d = 16'd0;
          end
        end else if (phase_q == gtus_pkg::PH_HS_NRFD) begin
          if (item_i.nrfd_released) phase_d = gtus_pkg::PH_HS_NDAC;
        end else if (phase_q == gtus_pkg::PH_HS_NDAC) begin
          if (item_i.ndac_released) begin
            first_d  = 1'b0;
            bticks_d = 16'd0;
            unique case (follow_q)
              gtus_pkg::FO_DATA: begin
                pending_d = inc_q;
                phase_d   = gtus_pkg::PH_HOST_NEXT;
              end
              gtus_pkg::FO_END: fin = 1'b1;
              gtus_pkg::FO_ACK: begin
                ack       = 1'b1;
                pending_d = 8'd0;
                phase_d   = gtus_pkg::PH_HOST_FIRST;
              end
              default: begin
                fin      = 1'b1;
                fin_code = gtus_pkg::ST_FORMAT;
              end
            endcase
          end
        end
      end
      gtus_pkg::ACT_TICK: begin
        if (phase_q != gtus_pkg::PH_IDLE) begin
          blk_d = blk_inc;
          if (in_wait) bticks_d = bticks_inc;
          if (expired) begin
            fin      = 1'b1;
            fin_code = wait_code;
          end
        end
      end
      default: phase_d = phase_q;
    endcase

    if (fin) begin
      err_d     = fin_code;
      phase_d   = gtus_pkg::PH_IDLE;
      pending_d = 8'd0;
      esc_d     = 1'b0;
    end
  end

  // result reflects the state after this word
  always_comb begin
    res_o.data_lines     = ((phase_d == gtus_pkg::PH_HOST_NEXT) ||
                            (phase_d == gtus_pkg::PH_HS_NRFD) ||
                            (phase_d == gtus_pkg::PH_HS_NDAC)) ? pending_d : 8'd0;
    res_o.dav_assert     = (phase_d == gtus_pkg::PH_HS_NDAC);
    res_o.eoi_assert     = ((phase_d == gtus_pkg::PH_HS_NRFD) ||
                            (phase_d == gtus_pkg::PH_HS_NDAC)) &&
                           (follow_d == gtus_pkg::FO_END) && cfg_i.eoi_enable;
    res_o.need_host_byte = (phase_d == gtus_pkg::PH_HOST_FIRST) ||
                           (phase_d == gtus_pkg::PH_HOST_NEXT);
    res_o.host_ack       = ack;
    res_o.status         = (phase_d == gtus_pkg::PH_IDLE) ? err_d : gtus_pkg::ST_BUSY;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= gtus_pkg::PH_IDLE;
      follow_q  <= gtus_pkg::FO_DATA;
      pending_q <= 8'd0;
      inc_q     <= 8'd0;
      esc_q     <= 1'b0;
      first_q   <= 1'b0;
      bticks_q  <= 16'd0;
      blk_q     <= 16'd0;
      err_q     <= gtus_pkg::ST_BUSY;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      follow_q  <= follow_d;
      pending_q <= pending_d;
      inc_q     <= inc_d;
      esc_q     <= esc_d;
      first_q   <= first_d;
      bticks_q  <= bticks_d;
      blk_q     <= blk_d;
      err_q     <= err_d;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == gtus_pkg::PH_IDLE) |-> (pending_q == 8'd0))
    else $error("pending byte held outside a block");

  a_esc_in_host_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> ((phase_q == gtus_pkg::PH_HOST_FIRST) || (phase_q == gtus_pkg::PH_HOST_NEXT)))
    else $error("escape pending outside host byte wait");

  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.action == gtus_pkg::ACT_START) |=>
      (phase_q == gtus_pkg::PH_LISTEN) && first_q && (blk_q == 16'd0))
    else $error("start did not open a block");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(blk_q))
    else $error("state moved without a word");

endmodule

FILE: rtl/gpib_talker_unstuff_send.sv
// Each accepted input word has its result word registered in res_q.
// Throughput: one word per cycle while out_ch.ready drains the output; the state
// update and the result register share a single clock, so the output register alone sets the pace.
// Reset (rst_ni low, asynchronous): block idle with status 0, registers at
// eoi_enable 1, byte_timeout 30, first_timeout 30, total_timeout 0.
module gpib_talker_unstuff_send (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtus_in_if.sink     in_ch,
  gtus_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gtus_pkg::cfg_t    cfg;
  gtus_pkg::item_t   item;
  gtus_pkg::result_t res_d, res_q;
  logic              out_valid_q;
  logic              fire;

  gtus_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign item.action        = in_ch.action;
  assign item.host_byte     = in_ch.host_byte;
  assign item.nrfd_released = in_ch.nrfd_released;
  assign item.ndac_released = in_ch.ndac_released;

  // take a word whenever the result register is empty or being drained
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  gtus_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (item),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.data_lines     = res_q.data_lines;
  assign out_ch.dav_assert     = res_q.dav_assert;
  assign out_ch.eoi_assert     = res_q.eoi_assert;
  assign out_ch.need_host_byte = res_q.need_host_byte;
  assign out_ch.host_ack       = res_q.host_ack;
  assign out_ch.status         = res_q.status;

endmodule
